// ===== rtl/stlu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlu_pkg
// Shared widths, codes and controller/datapath interface types for the
// sorted table interpolating lookup unit.
// ----------------------------------------------------------------------------
package stlu_pkg;

  localparam int DATA_W          = 32;
  localparam int IDX_W           = 10;
  localparam int CFG_W           = 11;
  localparam int WF_W            = 2;
  localparam int TABLE_DEPTH_DEF = 1024;

  // Interpolation arithmetic widths
  localparam int DIFF_W = DATA_W + 1;     // differences of two Q16.16 words
  localparam int HALF_W = 17;             // multiplier operand slice
  localparam int PROD_W = 2 * DIFF_W;     // full product
  localparam int CNT_W  = 6;              // divider step counter

  // Input item kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result location codes
  localparam logic [WF_W-1:0] WF_INSIDE = 2'd0;
  localparam logic [WF_W-1:0] WF_LOW    = 2'd1;
  localparam logic [WF_W-1:0] WF_HIGH   = 2'd2;

  // Read address selects
  localparam logic [1:0] AS_ZERO = 2'd0;
  localparam logic [1:0] AS_LAST = 2'd1;
  localparam logic [1:0] AS_ONE  = 2'd2;
  localparam logic [1:0] AS_NEXT = 2'd3;

  typedef struct packed {
    logic [1:0]      addr_sel;
    logic            wr_en;
    logic            q_load;
    logic            prev_load;
    logic            idx_set1;
    logic            idx_inc;
    logic            hi_load;
    logic            diff_load;
    logic            mul_lo;
    logic            mul_hi;
    logic            div_init;
    logic            div_step;
    logic            res_ram;
    logic            res_interp;
    logic [WF_W-1:0] res_wf;
    logic            out_load;
  } stlu_cmd_t;

  typedef struct packed {
    logic q_le;
    logic q_ge;
    logic at_last;
    logic div_last;
  } stlu_stat_t;

endpackage

// ===== rtl/sorted_table_interpolating_lookup_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_interpolating_lookup_unit
// Piecewise-linear table lookup: maps a Q16.16 value to its Q16.16 equivalent.
// ----------------------------------------------------------------------------
// A load item writes one table entry. A query item reads the first entry
// and, unless it is clamped at the low end, then the last used entry; a
// query clamped at either end presents its result without a scan.
// Otherwise the value memory is scanned one entry a cycle from entry 1 to
// the first entry above the query. The slope product is then formed in two
// multiplier passes and divided by a restoring divider at one quotient bit
// a cycle. The next item can be taken in the cycle after a result is handed
// to the output register. The scan through the single read port of the
// value memory and the bit-serial divider set the time a query takes. One
// item is processed at a time. A finished result waits in the output
// register while the next item is taken; a second result waits until the
// first is taken, and the input stalls meanwhile. entries_used is to be
// written only while idle, by the user; the block does not enforce this.
module sorted_table_interpolating_lookup_unit #(
  parameter int TABLE_DEPTH = stlu_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [stlu_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_mode,
  input  logic [stlu_pkg::IDX_W-1:0]         in_entry_index,
  input  logic signed [stlu_pkg::DATA_W-1:0] in_entry_value,
  input  logic signed [stlu_pkg::DATA_W-1:0] in_entry_equivalent,
  input  logic signed [stlu_pkg::DATA_W-1:0] in_query_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [stlu_pkg::DATA_W-1:0] out_equivalent,
  output logic [stlu_pkg::WF_W-1:0]          out_where_found
);
  import stlu_pkg::*;

  stlu_cmd_t  cmd;
  stlu_stat_t st;

  stlu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  stlu_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_entry_index      (in_entry_index),
    .in_entry_value      (in_entry_value),
    .in_entry_equivalent (in_entry_equivalent),
    .in_query_value      (in_query_value),
    .cmd                 (cmd),
    .st                  (st),
    .out_equivalent      (out_equivalent),
    .out_where_found     (out_where_found)
  );

endmodule

// ===== rtl/stlu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlu_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module stlu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/stlu_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlu_datapath
// Table memories, entry count register, scan registers, split multiplier,
// bit-serial divider and result registers.
// ----------------------------------------------------------------------------
module stlu_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [stlu_pkg::CFG_W-1:0]        cfg_wr_data,
  input  logic [stlu_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [stlu_pkg::DATA_W-1:0] in_entry_value,
  input  logic signed [stlu_pkg::DATA_W-1:0] in_entry_equivalent,
  input  logic signed [stlu_pkg::DATA_W-1:0] in_query_value,
  input  stlu_pkg::stlu_cmd_t               cmd,
  output stlu_pkg::stlu_stat_t              st,
  output logic signed [stlu_pkg::DATA_W-1:0] out_equivalent,
  output logic [stlu_pkg::WF_W-1:0]         out_where_found
);
  import stlu_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CFG_W-1:0]   cfg_r;
  logic [AW-1:0]      last_idx;
  logic [AW-1:0]      idx_r;
  logic [AW-1:0]      rd_addr;
  logic               ld_in_range;
  logic [DATA_W-1:0]  rd_v;
  logic [DATA_W-1:0]  rd_e;
  logic [DATA_W-1:0]  q_r;
  logic [DATA_W-1:0]  v0_r;
  logic [DATA_W-1:0]  e0_r;
  logic [DATA_W-1:0]  v1_r;
  logic [DATA_W-1:0]  e1_r;
  logic [DIFF_W-1:0]  dq_r;
  logic [DIFF_W-1:0]  dv_r;
  logic [DIFF_W-1:0]  mag_r;
  logic               neg_r;
  logic [DIFF_W-1:0]  de;
  logic [HALF_W-1:0]  mul_b;
  logic [DIFF_W+HALF_W-1:0] part;
  logic [PROD_W-1:0]  prod_r;
  logic [DIFF_W-1:0]  rem_r;
  logic [DIFF_W-1:0]  nb_r;
  logic [DIFF_W:0]    trial;
  logic [DIFF_W:0]    trial_sub;
  logic [CNT_W-1:0]   cnt_r;
  logic [DATA_W-1:0]  res_r;
  logic [WF_W-1:0]    wf_r;
  logic [DATA_W-1:0]  interp;

  // Entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // Last used entry: zero counts as one, clamp to the table depth
  always_comb begin
    if (cfg_r == '0) begin
      last_idx = '0;
    end else if (32'(cfg_r) > 32'(TABLE_DEPTH)) begin
      last_idx = AW'(TABLE_DEPTH - 1);
    end else begin
      last_idx = AW'(32'(cfg_r) - 32'd1);
    end
  end

  assign ld_in_range = 32'(in_entry_index) < 32'(TABLE_DEPTH);

  // Read address select
  always_comb begin
    unique case (cmd.addr_sel)
      AS_ZERO: rd_addr = '0;
      AS_LAST: rd_addr = last_idx;
      AS_ONE:  rd_addr = AW'(1);
      AS_NEXT: rd_addr = idx_r + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  stlu_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en && ld_in_range),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (in_entry_value),
    .rd_addr (rd_addr),
    .rd_data (rd_v)
  );

  stlu_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_eqv_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en && ld_in_range),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (in_entry_equivalent),
    .rd_addr (rd_addr),
    .rd_data (rd_e)
  );

  // Compares against the entry just read
  assign st.q_le     = $signed(q_r) <= $signed(rd_v);
  assign st.q_ge     = $signed(q_r) >= $signed(rd_v);
  assign st.at_last  = idx_r == last_idx;
  assign st.div_last = cnt_r == CNT_W'(DIFF_W - 1);

  // Query and bracketing entries
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      q_r <= in_query_value;
    end
    if (cmd.prev_load) begin
      v0_r <= rd_v;
      e0_r <= rd_e;
    end
    if (cmd.hi_load) begin
      v1_r <= rd_v;
      e1_r <= rd_e;
    end
    if (cmd.idx_set1) begin
      idx_r <= AW'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // Differences and sign-magnitude slope numerator
  assign de = {e1_r[DATA_W-1], e1_r} - {e0_r[DATA_W-1], e0_r};

  always_ff @(posedge clk) begin
    if (cmd.diff_load) begin
      dq_r  <= {q_r[DATA_W-1], q_r} - {v0_r[DATA_W-1], v0_r};
      dv_r  <= {v1_r[DATA_W-1], v1_r} - {v0_r[DATA_W-1], v0_r};
      neg_r <= de[DIFF_W-1];
      mag_r <= de[DIFF_W-1] ? (~de + DIFF_W'(1)) : de;
    end
  end

  // Product in two partial products: low slice, then high slice
  assign mul_b = cmd.mul_hi ? HALF_W'(mag_r[DIFF_W-1:HALF_W]) : mag_r[HALF_W-1:0];
  assign part  = dq_r * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      prod_r <= PROD_W'(part);
    end else if (cmd.mul_hi) begin
      prod_r <= prod_r + PROD_W'({part, {HALF_W{1'b0}}});
    end
  end

  // Restoring divider, one quotient bit per step; quotient stays below 2^33
  assign trial     = {rem_r, nb_r[DIFF_W-1]};
  assign trial_sub = trial - {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= prod_r[PROD_W-1:DIFF_W];
      nb_r  <= prod_r[DIFF_W-1:0];
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, dv_r}) begin
        rem_r <= trial_sub[DIFF_W-1:0];
        nb_r  <= {nb_r[DIFF_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIFF_W-1:0];
        nb_r  <= {nb_r[DIFF_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign interp = neg_r ? (e0_r - nb_r[DATA_W-1:0]) : (e0_r + nb_r[DATA_W-1:0]);

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.res_ram) begin
      res_r <= rd_e;
      wf_r  <= cmd.res_wf;
    end else if (cmd.res_interp) begin
      res_r <= interp;
      wf_r  <= cmd.res_wf;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_equivalent  <= res_r;
      out_where_found <= wf_r;
    end
  end

endmodule

// ===== rtl/stlu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlu_ctrl
// Sequencer for loads and queries: bracket checks, entry scan, multiply,
// divide and result hand-off.
// ----------------------------------------------------------------------------
module stlu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_mode,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  stlu_pkg::stlu_stat_t st,
  output stlu_pkg::stlu_cmd_t  cmd
);
  import stlu_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD0  = 4'd1;
  localparam logic [3:0] ST_RDN  = 4'd2;
  localparam logic [3:0] ST_SCAN = 4'd3;
  localparam logic [3:0] ST_DIFF = 4'd4;
  localparam logic [3:0] ST_MULL = 4'd5;
  localparam logic [3:0] ST_MULH = 4'd6;
  localparam logic [3:0] ST_DIVI = 4'd7;
  localparam logic [3:0] ST_DIV  = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;
  logic       in_acc;

  assign in_stall  = state_r != ST_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.addr_sel = AS_ZERO;
    cmd.res_wf   = WF_INSIDE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.q_load = 1'b1;
            state_nxt  = ST_RD0;
          end
        end
      end
      ST_RD0: begin
        cmd.prev_load = 1'b1;
        if (st.q_le) begin
          cmd.res_ram = 1'b1;
          cmd.res_wf  = WF_LOW;
          state_nxt   = ST_DONE;
        end else begin
          cmd.addr_sel = AS_LAST;
          state_nxt    = ST_RDN;
        end
      end
      ST_RDN: begin
        if (st.q_ge) begin
          cmd.res_ram = 1'b1;
          cmd.res_wf  = WF_HIGH;
          state_nxt   = ST_DONE;
        end else begin
          cmd.addr_sel = AS_ONE;
          cmd.idx_set1 = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Stop at the first entry above the query
        if (!st.q_ge || st.at_last) begin
          cmd.hi_load = 1'b1;
          state_nxt   = ST_DIFF;
        end else begin
          cmd.prev_load = 1'b1;
          cmd.idx_inc   = 1'b1;
          cmd.addr_sel  = AS_NEXT;
        end
      end
      ST_DIFF: begin
        cmd.diff_load = 1'b1;
        state_nxt     = ST_MULL;
      end
      ST_MULL: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MULH;
      end
      ST_MULH: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_DIVI;
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.res_interp = 1'b1;
        cmd.res_wf     = WF_INSIDE;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on hand-off, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register overwritten while held");

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode == MODE_QUERY) |=> state_r == ST_RD0)
    else $error("query did not start bracket check");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && st.at_last |=> state_r == ST_DIFF)
    else $error("scan ran past last used entry");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && st.div_last |=> state_r == ST_FIN)
    else $error("divider overran");
`endif

endmodule

// ===== tb/stlu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stlu_checker
// Watches the configuration port and both item channels of the lookup unit.
// Keeps its own copy of the table and the entry count, works out the
// expected equivalent and location of every accepted query, and compares
// each accepted result in order. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module stlu_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [stlu_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_mode,
  input  logic [stlu_pkg::IDX_W-1:0]         in_entry_index,
  input  logic signed [stlu_pkg::DATA_W-1:0] in_entry_value,
  input  logic signed [stlu_pkg::DATA_W-1:0] in_entry_equivalent,
  input  logic signed [stlu_pkg::DATA_W-1:0] in_query_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [stlu_pkg::DATA_W-1:0] out_equivalent,
  input  logic [stlu_pkg::WF_W-1:0]          out_where_found,
  output int                                 fail_count,
  output int                                 results_pending
);
  import stlu_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  typedef struct {
    logic [DATA_W-1:0] equivalent;
    logic [WF_W-1:0]   where_found;
  } lookup_result_t;

  logic signed [DATA_W-1:0] value_mem [DEPTH];
  logic signed [DATA_W-1:0] equiv_mem [DEPTH];
  logic [CFG_W-1:0]         entries_used;
  lookup_result_t           lookup_q [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  // Map one query value to its equivalent from the current table
  function automatic lookup_result_t lookup_equivalent(input logic signed [DATA_W-1:0] q);
    lookup_result_t        r;
    int                    n;
    int                    k;
    longint                v0;
    longint                v1;
    longint                e0;
    longint                de;
    longint unsigned       dq;
    longint unsigned       dv;
    longint unsigned       mag;
    longint unsigned       quo;
    n = entries_used;
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    if (q <= value_mem[0]) begin
      r.equivalent  = equiv_mem[0];
      r.where_found = WF_LOW;
      return r;
    end
    if (q >= value_mem[n-1]) begin
      r.equivalent  = equiv_mem[n-1];
      r.where_found = WF_HIGH;
      return r;
    end
    k = 1;
    while (k < n - 1 && value_mem[k] <= q) k++;
    v0  = value_mem[k-1];
    v1  = value_mem[k];
    e0  = equiv_mem[k-1];
    de  = longint'(equiv_mem[k]) - e0;
    dq  = longint'(q) - v0;
    dv  = v1 - v0;
    mag = (de < 0) ? -de : de;
    quo = (dq * mag) / dv;
    r.equivalent  = (de < 0) ? (e0[DATA_W-1:0] - quo[DATA_W-1:0])
                             : (e0[DATA_W-1:0] + quo[DATA_W-1:0]);
    r.where_found = WF_INSIDE;
    return r;
  endfunction

  // Track configuration, predict on input, compare on output
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      entries_used = 1;
      lookup_q.delete();
      fail_count   = 0;
    end else begin
      if (cfg_wr_en) entries_used = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (lookup_q.size() == 0) begin
          report_mismatch($sformatf("result %h/%0d with nothing expected",
                                    out_equivalent, out_where_found));
        end else begin
          want = lookup_q.pop_front();
          if (out_equivalent !== want.equivalent)
            report_mismatch($sformatf("equivalent %h, expected %h",
                                      out_equivalent, want.equivalent));
          if (out_where_found !== want.where_found)
            report_mismatch($sformatf("where_found %0d, expected %0d",
                                      out_where_found, want.where_found));
        end
      end
      if (in_valid && !in_stall) begin
        if (in_mode == MODE_LOAD) begin
          value_mem[in_entry_index] = in_entry_value;
          equiv_mem[in_entry_index] = in_entry_equivalent;
        end else begin
          lookup_q.push_back(lookup_equivalent(in_query_value));
        end
      end
    end
    results_pending = lookup_q.size();
  end

endmodule

// ===== tb/tb_sorted_table_interpolating_lookup_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_interpolating_lookup_unit
// Drives load and query items into the lookup unit under random idling and
// stalls, across several entry counts from one up to the full table, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_sorted_table_interpolating_lookup_unit;
  import stlu_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VMAX = 32'sh7fff_ffff;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [CFG_W-1:0]         cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_mode;
  logic [IDX_W-1:0]         in_entry_index;
  logic signed [DATA_W-1:0] in_entry_value;
  logic signed [DATA_W-1:0] in_entry_equivalent;
  logic signed [DATA_W-1:0] in_query_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_equivalent;
  logic [WF_W-1:0]          out_where_found;
  int                       fail_count;
  int                       results_pending;

  logic signed [DATA_W-1:0] table_copy [DEPTH];
  int                       live_count;
  bit                       quiet;
  bit                       hold_req;
  bit                       hold_done;
  int                       hold_left;

  sorted_table_interpolating_lookup_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_entry_index      (in_entry_index),
    .in_entry_value      (in_entry_value),
    .in_entry_equivalent (in_entry_equivalent),
    .in_query_value      (in_query_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_equivalent      (out_equivalent),
    .out_where_found     (out_where_found)
  );

  stlu_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Stall the result channel at random; one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 23);
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] val,
                           input logic signed [DATA_W-1:0] eqv,
                           input logic signed [DATA_W-1:0] q);
    while (!quiet && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_mode             <= mode;
    in_entry_index      <= idx;
    in_entry_value      <= val;
    in_entry_equivalent <= eqv;
    in_query_value      <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_entry(input int idx, input logic signed [DATA_W-1:0] val,
                            input logic signed [DATA_W-1:0] eqv);
    table_copy[idx] = val;
    send_item(MODE_LOAD, IDX_W'(idx), val, eqv, $urandom);
  endtask

  task automatic query(input logic signed [DATA_W-1:0] q);
    send_item(MODE_QUERY, IDX_W'($urandom), $urandom, $urandom, q);
  endtask

  // Drain, let a trailing load finish, then write the entry count
  task automatic set_count(input int raw);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(raw);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    live_count = (raw == 0) ? 1 : (raw > DEPTH) ? DEPTH : raw;
  endtask

  // Load an ascending table, with duplicates; now and then scrambled
  task automatic fill_table(input int n, input bit scramble);
    longint v;
    longint step_max;
    v = $urandom_range(0, 1) ? longint'(VMIN) : longint'(VMIN) + $urandom_range(0, 32'h7fff_ffff);
    step_max = (longint'(VMAX) - v) / n;
    if (step_max < 1) step_max = 1;
    for (int i = 0; i < n; i++) begin
      if (scramble) load_entry(i, $urandom, $urandom);
      else load_entry(i, DATA_W'(v), $urandom);
      if ($urandom_range(0, 9) != 0) v += $urandom_range(1, step_max);
    end
  endtask

  // Pick a query near the table, inside it, or anywhere
  function automatic logic signed [DATA_W-1:0] pick_query();
    int     k;
    longint a;
    longint b;
    k = $urandom_range(0, live_count - 1);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2, 3: return table_copy[k] + $signed($urandom_range(0, 4)) - 2;
      default: begin
        a = table_copy[k];
        b = (k + 1 < live_count) ? longint'(table_copy[k+1]) : a;
        if (b < a) return $urandom;
        return DATA_W'(a + ($urandom % (b - a + 1)));
      end
    endcase
  endfunction

  // Pick a query near the loaded front of a partly filled table, below entry top
  function automatic logic signed [DATA_W-1:0] pick_below(input int top);
    int     k;
    longint q;
    k = $urandom_range(0, top);
    q = longint'(table_copy[k]) + longint'($urandom_range(0, 4)) - 2;
    if (q >= longint'(table_copy[top])) q = longint'(table_copy[top]) - 1;
    if (q < longint'(VMIN)) q = longint'(VMIN);
    return DATA_W'(q);
  endfunction

  initial begin
    int n;
    int rand_items;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_mode     = MODE_LOAD;
    in_entry_index      = '0;
    in_entry_value      = '0;
    in_entry_equivalent = '0;
    in_query_value      = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    live_count  = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single entry after reset: clamp low at or below, high above
    load_entry(0, 0, 32'sd1000);
    query(VMIN);
    query(0);
    query(1);
    query(VMAX);

    // Extremes of value and equivalent, interpolation with a wide span
    set_count(4);
    load_entry(0, VMIN, VMAX);
    load_entry(1, -5, VMIN);
    load_entry(2, 100, 0);
    load_entry(3, VMAX, 7);
    query(VMIN + 1);
    query(-5);
    query(-4);
    query(99);
    query(100);
    query(VMAX - 1);
    query(VMAX);
    query(50);

    // Zero count behaves as one
    set_count(0);
    query(VMIN);
    query(VMAX);

    // Count at the depth, then beyond it; the scan stays in the loaded front
    set_count(DEPTH);
    fill_table(64, 1'b0);
    load_entry(DEPTH - 1, VMAX, $urandom);
    for (int i = 0; i < 6; i++) query(pick_below(63));
    query(VMAX);
    set_count(2047);
    for (int i = 0; i < 6; i++) query(pick_below(63));

    // Random phases over small tables
    rand_items = 0;
    while (rand_items < 720) begin
      n = $urandom_range(0, 7) == 0 ? 64 : $urandom_range(2, 16);
      set_count(n);
      quiet = (rand_items > 150 && rand_items < 300);
      fill_table(n, $urandom_range(0, 5) == 0);
      rand_items += n;
      if (rand_items > 300) hold_req = 1'b1;
      for (int i = $urandom_range(20, 50); i > 0; i--) begin
        query(pick_query());
        rand_items++;
      end
    end
    quiet = 1'b0;

    // Drain and give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/stlu_pkg.sv
rtl/stlu_ram.sv
rtl/stlu_datapath.sv
rtl/stlu_ctrl.sv
rtl/sorted_table_interpolating_lookup_unit.sv
tb/stlu_checker.sv
tb/tb_sorted_table_interpolating_lookup_unit.sv
